@@ src/vfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vfm_pkg;

   // Window geometry.
   localparam int MIRROR_BYTES       = 131072;
   localparam int ADDR_W             = 17;
   localparam int LANES              = 8;
   localparam int LANE_W             = 3;
   localparam int ROW_W              = ADDR_W - LANE_W;
   localparam int MIRROR_ROWS        = MIRROR_BYTES / LANES;
   localparam int VIDEO_WIDTH        = 320;
   localparam int VIDEO_HEIGHT       = 200;
   localparam int VIDEO_CELLS        = VIDEO_WIDTH * VIDEO_HEIGHT;
   localparam int TEXT_COLUMNS       = 80;
   localparam int TEXT_ROWS          = 25;
   localparam int TEXT_CELLS         = TEXT_COLUMNS * TEXT_ROWS;
   localparam int TEXT_REGION_OFFSET = 98304;

   // Mode port values.
   localparam logic [7:0] MODE_VIDEO = 8'h13;
   localparam logic [7:0] MODE_TEXT  = 8'h03;

   // Notice codes.
   localparam logic [1:0] NOTIFY_NONE  = 2'd0;
   localparam logic [1:0] NOTIFY_TEXT  = 2'd1;
   localparam logic [1:0] NOTIFY_VIDEO = 2'd2;

   typedef enum logic [1:0] {
      OP_MEM_READ   = 2'd0,
      OP_MEM_WRITE  = 2'd1,
      OP_MODE_READ  = 2'd2,
      OP_MODE_WRITE = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              clear;
      logic [ROW_W-1:0]  clear_row;
      logic              accept;
      logic              load_imm;
      logic              load_read;
   } cmd_type;

endpackage

`default_nettype wire

@@ src/vfm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vfm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vfm_pkg::cmd_type              cmd,
   input  wire logic [1:0]                    req_op,
   input  wire logic [vfm_pkg::ADDR_W-1:0]    req_offset,
   input  wire logic [3:0]                    req_len,
   input  wire logic [63:0]                   req_data,
   input  wire logic                          csr_write,
   input  wire logic                          csr_data,
   output logic [63:0]                        rsp_read_data,
   output logic                               rsp_status,
   output logic [1:0]                         rsp_notify
);

   logic [7:0]  mode_ff;
   logic [7:0]  mode_in;
   logic        clients_ff;

   logic [vfm_pkg::LANE_W-1:0] off_lo_ff;
   logic [3:0]                 n_ff;
   logic [63:0]                data_ff;
   logic                       inb_ff;
   logic [7:0]                 rd_bank_ff [vfm_pkg::LANES];

   logic [63:0] rd_data_ff;
   logic        status_ff;
   logic [1:0]  notify_ff;

   logic [3:0]                 n;
   logic [vfm_pkg::ADDR_W:0]   end_addr;
   logic                       mirror_ok;
   logic                       video_ok;
   logic                       text_ok;
   logic [vfm_pkg::ADDR_W:0]   text_end;
   logic [vfm_pkg::ROW_W-1:0]  bank_row [vfm_pkg::LANES];
   logic                       bank_we  [vfm_pkg::LANES];
   logic [7:0]                 bank_wd  [vfm_pkg::LANES];
   logic [63:0]                read_word;
   logic [63:0]                imm_data;
   logic                       imm_status;
   logic [1:0]                 imm_notify;

   // Byte count saturates at eight; bound checks on the end address.
   always_comb begin
      n         = (req_len > 4'd8) ? 4'd8 : req_len;
      end_addr  = {1'b0, req_offset} + {{(vfm_pkg::ADDR_W - 3){1'b0}}, n};
      mirror_ok = !end_addr[vfm_pkg::ADDR_W];
      video_ok  = end_addr < (vfm_pkg::ADDR_W + 1)'(vfm_pkg::VIDEO_CELLS);
      text_end  = end_addr - (vfm_pkg::ADDR_W + 1)'(vfm_pkg::TEXT_REGION_OFFSET);
      text_ok   = (req_offset >= vfm_pkg::ADDR_W'(vfm_pkg::TEXT_REGION_OFFSET)) &&
                  (text_end < (vfm_pkg::ADDR_W + 1)'(vfm_pkg::TEXT_CELLS));
   end

   // Bank addressing: bank b carries the lane whose byte address ends in b.
   always_comb begin
      for (int b = 0; b < vfm_pkg::LANES; b++) begin
         logic [vfm_pkg::LANE_W-1:0] lane;
         logic [vfm_pkg::ADDR_W:0]   addr;
         lane = vfm_pkg::LANE_W'(b) - req_offset[vfm_pkg::LANE_W-1:0];
         addr = {1'b0, req_offset} + {{(vfm_pkg::ADDR_W + 1 - vfm_pkg::LANE_W){1'b0}}, lane};
         if (cmd.clear) begin
            bank_row[b] = cmd.clear_row;
            bank_we[b]  = 1'b1;
            bank_wd[b]  = 8'h00;
         end else begin
            bank_row[b] = addr[vfm_pkg::ADDR_W-1:vfm_pkg::LANE_W];
            bank_we[b]  = cmd.accept && (req_op == vfm_pkg::OP_MEM_WRITE) && mirror_ok &&
                          ({1'b0, lane} < n);
            bank_wd[b]  = req_data[8*lane +: 8];
         end
      end
   end

   // Mirror memory in eight byte-wide banks.
   for (genvar g = 0; g < vfm_pkg::LANES; g++) begin : g_bank
      logic [7:0] mem [vfm_pkg::MIRROR_ROWS];
      always_ff @(posedge clock) begin
         if (bank_we[g]) begin
            mem[bank_row[g]] <= bank_wd[g];
         end
         rd_bank_ff[g] <= mem[bank_row[g]];
      end
   end

   // Read merge: for an in-mirror access, low n lanes from the mirror, the rest from the request.
   always_comb begin
      read_word = data_ff;
      if (inb_ff) begin
         for (int i = 0; i < vfm_pkg::LANES; i++) begin
            if (i < n_ff) begin
               read_word[8*i +: 8] = rd_bank_ff[vfm_pkg::LANE_W'(i) + off_lo_ff];
            end
         end
      end
   end

   // Results for the ops that finish in the accept cycle.
   always_comb begin
      imm_data   = 64'd0;
      imm_status = 1'b0;
      imm_notify = vfm_pkg::NOTIFY_NONE;
      mode_in    = mode_ff;
      case (req_op)
         vfm_pkg::OP_MEM_WRITE: begin
            if (mode_ff == vfm_pkg::MODE_TEXT) begin
               imm_status = !text_ok;
               imm_notify = (text_ok && clients_ff) ? vfm_pkg::NOTIFY_TEXT
                                                    : vfm_pkg::NOTIFY_NONE;
            end else if (mode_ff == vfm_pkg::MODE_VIDEO) begin
               imm_status = !video_ok;
               imm_notify = (video_ok && clients_ff) ? vfm_pkg::NOTIFY_VIDEO
                                                     : vfm_pkg::NOTIFY_NONE;
            end else begin
               imm_status = 1'b1;
            end
         end
         vfm_pkg::OP_MODE_READ: begin
            imm_data = {56'd0, mode_ff};
         end
         vfm_pkg::OP_MODE_WRITE: begin
            if (req_data[7:0] == vfm_pkg::MODE_VIDEO ||
                req_data[7:0] == vfm_pkg::MODE_TEXT) begin
               mode_in = req_data[7:0];
            end
         end
         default: begin
            imm_data = req_data;
         end
      endcase
   end

   // Control registers: mode and client flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= vfm_pkg::MODE_VIDEO;
         clients_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            mode_ff <= mode_in;
         end
         if (csr_write) begin
            clients_ff <= csr_data;
         end
      end
   end

   // Request capture and result register.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         off_lo_ff <= req_offset[vfm_pkg::LANE_W-1:0];
         n_ff      <= n;
         data_ff   <= req_data;
         inb_ff    <= mirror_ok;
      end
      if (cmd.load_imm) begin
         rd_data_ff <= imm_data;
         status_ff  <= imm_status;
         notify_ff  <= imm_notify;
      end else if (cmd.load_read) begin
         rd_data_ff <= read_word;
         status_ff  <= 1'b0;
         notify_ff  <= vfm_pkg::NOTIFY_NONE;
      end
   end

   assign rsp_read_data = rd_data_ff;
   assign rsp_status    = status_ff;
   assign rsp_notify    = notify_ff;

endmodule

`default_nettype wire

@@ src/vfm_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vfm_controller (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_is_read,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output vfm_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT
   } state_type;

   state_type                  state_ff;
   logic [vfm_pkg::ROW_W-1:0]  row_ff;
   logic                       rsp_valid_ff;
   logic                       slot_free;
   logic                       accept;

   // A beat is taken when idle and the result slot is free or draining.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.clear     = (state_ff == ST_CLEAR);
      cmd.clear_row = row_ff;
      cmd.accept    = accept;
      cmd.load_imm  = accept && !req_is_read;
      cmd.load_read = (state_ff == ST_READ_WAIT);
   end

   // State, clear sweep counter and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               row_ff <= row_ff + 1'b1;
               if (&row_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && req_is_read) begin
                  state_ff <= ST_READ_WAIT;
               end
            end
            ST_READ_WAIT: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cmd.load_imm || cmd.load_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/vga_framebuffer_mirror_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// VGA memory window with a zero-initialized mirror memory and a mode port.
// Request channel (req_valid / req_stall): one beat is one access, a byte-lane
// read or write of up to eight bytes at req_offset, or a mode port access.
// Response channel (rsp_valid / rsp_stall): one beat per request, carrying the
// read data, the out-of-plane status and the update notice code.
// Configuration channel (csr_valid / csr_ready): one bit, clients present;
// csr_ready is always high.
// Timing: writes and mode accesses answer in the cycle after acceptance; memory
// reads pass the registered read port of the mirror banks and then the result
// register. A write or mode access can be taken every cycle while the receiver
// does not stall; a memory read holds the request side in the read-wait state,
// so a new request is taken only once the read data is in the result register.
// Reset: after reset is released the block clears all 16384 mirror rows, one
// 8-byte row per cycle, with req_stall high; the mode starts as video.
// When the receiver stalls, the result is held in the output register and a
// new request is taken only in the cycle in which that result is delivered.
module vga_framebuffer_mirror_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_op,
   input  wire logic [vfm_pkg::ADDR_W-1:0]  req_offset,
   input  wire logic [3:0]                  req_len,
   input  wire logic [63:0]                 req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [63:0]                      rsp_read_data,
   output logic                             rsp_status,
   output logic [1:0]                       rsp_notify,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_data
);

   vfm_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   vfm_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_read (req_op == vfm_pkg::OP_MEM_READ),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   vfm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_offset    (req_offset),
      .req_len       (req_len),
      .req_data      (req_data),
      .csr_write     (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_notify    (rsp_notify)
   );

endmodule

`default_nettype wire

@@ bench/vga_framebuffer_mirror_unit_tb.sv @@
`timescale 1ns / 1ps

module vga_framebuffer_mirror_unit_tb;

   // Cycles without any beat before the run is declared hung; the longest
   // quiet stretch is the mirror clear after reset.
   localparam int HANG_LIMIT = 300000;
   localparam int PHASE_ITEMS = 425;

   typedef struct {
      logic [63:0] read_data;
      logic        status;
      logic [1:0]  notify;
   } result_type;

   // Tracks the window contents and the mode, and holds the answers due.
   class scoreboard_type;
      byte unsigned   mirror [vfm_pkg::MIRROR_BYTES];
      logic [7:0]     mode;
      bit             clients;
      result_type     due_q[$];
      int             errors;

      function new();
         foreach (mirror[i]) mirror[i] = 0;
         mode = vfm_pkg::MODE_VIDEO;
         clients = 0;
         errors = 0;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      endtask

      // Works out the answer to one accepted access and updates the state.
      function void note_access(logic [1:0] op, logic [16:0] offset, logic [3:0] len,
                                logic [63:0] data);
         result_type   r;
         int           n;
         bit           in_mirror;
         bit           plane_ok;
         logic [31:0]  text_idx;
         n = (len > 8) ? 8 : int'(len);
         in_mirror = (longint'(offset) < longint'(vfm_pkg::MIRROR_BYTES - n));
         r.read_data = '0;
         r.status = 1'b0;
         r.notify = vfm_pkg::NOTIFY_NONE;
         case (vfm_pkg::op_type'(op))
            vfm_pkg::OP_MEM_READ: begin
               r.read_data = data;
               if (in_mirror)
                  for (int i = 0; i < n; i++) r.read_data[8*i +: 8] = mirror[offset + i];
            end
            vfm_pkg::OP_MEM_WRITE: begin
               if (in_mirror)
                  for (int i = 0; i < n; i++) mirror[offset + i] = data[8*i +: 8];
               if (mode == vfm_pkg::MODE_TEXT) begin
                  text_idx = 32'(offset) - 32'(vfm_pkg::TEXT_REGION_OFFSET);
                  plane_ok = (longint'(text_idx) < longint'(vfm_pkg::TEXT_CELLS - n));
                  if (plane_ok) r.notify = clients ? vfm_pkg::NOTIFY_TEXT
                                                   : vfm_pkg::NOTIFY_NONE;
                  else r.status = 1'b1;
               end else if (mode == vfm_pkg::MODE_VIDEO) begin
                  plane_ok = (longint'(offset) < longint'(vfm_pkg::VIDEO_CELLS - n));
                  if (plane_ok) r.notify = clients ? vfm_pkg::NOTIFY_VIDEO
                                                   : vfm_pkg::NOTIFY_NONE;
                  else r.status = 1'b1;
               end else begin
                  r.status = 1'b1;
               end
            end
            vfm_pkg::OP_MODE_READ: begin
               r.read_data = {56'd0, mode};
            end
            default: begin
               // Only the two known modes are ever stored.
               if (data[7:0] == vfm_pkg::MODE_VIDEO || data[7:0] == vfm_pkg::MODE_TEXT)
                  mode = data[7:0];
            end
         endcase
         due_q.push_back(r);
      endfunction

      // Compares one delivered answer with the oldest one due.
      task check_result(logic [63:0] rd, logic st, logic [1:0] nt);
         result_type w;
         if (due_q.size() == 0) begin
            report("unexpected response read_data", rd, 64'd0);
         end else begin
            w = due_q.pop_front();
            if (rd !== w.read_data) report("read_data", rd, w.read_data);
            if (st !== w.status) report("status", 64'(st), 64'(w.status));
            if (nt !== w.notify) report("notify", 64'(nt), 64'(w.notify));
         end
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = vfm_pkg::OP_MODE_READ;
   logic [16:0] req_offset = '0;
   logic [3:0]  req_len = 4'd1;
   logic [63:0] req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_read_data;
   logic        rsp_status;
   logic [1:0]  rsp_notify;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_data = 0;

   scoreboard_type sb = new();
   bit  idle_enable = 1;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   vga_framebuffer_mirror_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_offset(req_offset), .req_len(req_len), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status), .rsp_notify(rsp_notify),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Observe beats on both channels and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_access(req_op, req_offset, req_len, req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_read_data, rsp_status, rsp_notify);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Receiver stalls in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 11) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sends one access and waits for the beat to be taken.
   task send_access(logic [1:0] op, logic [16:0] offset, logic [3:0] len, logic [63:0] data);
      int gap;
      if (idle_enable && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_offset <= offset;
      req_len <= len;
      req_data <= data;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Waits until every answer has come back, then lets the pipeline drain.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_clients(bit value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.clients = value;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Offsets favor small hot windows so that reads see written bytes, and the
   // edges of the mirror and of both planes.
   function automatic logic [16:0] rand_offset();
      case ($urandom_range(0, 7))
         0, 1: return 17'($urandom_range(0, 255));
         2, 3: return 17'($urandom_range(vfm_pkg::TEXT_REGION_OFFSET,
                                         vfm_pkg::TEXT_REGION_OFFSET + 255));
         4: return 17'($urandom_range(vfm_pkg::VIDEO_CELLS - 12, vfm_pkg::VIDEO_CELLS + 4));
         5: return 17'($urandom_range(vfm_pkg::TEXT_REGION_OFFSET + vfm_pkg::TEXT_CELLS - 12,
                                      vfm_pkg::TEXT_REGION_OFFSET + vfm_pkg::TEXT_CELLS + 4));
         6: return 17'($urandom_range(vfm_pkg::MIRROR_BYTES - 12, vfm_pkg::MIRROR_BYTES - 1));
         default: return 17'($urandom());
      endcase
   endfunction

   // Lengths are mostly 1 to 8, with the occasional zero or oversized count.
   function automatic logic [3:0] rand_len();
      if ($urandom_range(0, 19) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   task random_access();
      logic [1:0]  op;
      logic [63:0] data;
      int          pick;
      pick = $urandom_range(0, 149);
      data = rand_word();
      if (pick == 0) begin
         op = vfm_pkg::OP_MODE_WRITE;
         case ($urandom_range(0, 2))
            0: data[7:0] = vfm_pkg::MODE_VIDEO;
            1: data[7:0] = vfm_pkg::MODE_TEXT;
            default: ;
         endcase
      end else if (pick < 6) begin
         op = vfm_pkg::OP_MODE_READ;
      end else if (pick < 70) begin
         op = vfm_pkg::OP_MEM_READ;
      end else begin
         op = vfm_pkg::OP_MEM_WRITE;
      end
      send_access(op, rand_offset(), rand_len(), data);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed accesses over edges, modes and partial lanes.
      send_access(vfm_pkg::OP_MODE_READ, 17'd0, 4'd1, '1);
      send_access(vfm_pkg::OP_MEM_READ, 17'd0, 4'd8, '1);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'd0, 4'd8, '1);
      send_access(vfm_pkg::OP_MEM_READ, 17'd0, 4'd3, 64'h0123_4567_89ab_cdef);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::VIDEO_CELLS - 9), 4'd8,
                  64'h1122_3344_5566_7788);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::VIDEO_CELLS - 8), 4'd8, rand_word());
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::MIRROR_BYTES - 2), 4'd1, 64'hab);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::MIRROR_BYTES - 1), 4'd1, 64'hcd);
      send_access(vfm_pkg::OP_MEM_READ, 17'(vfm_pkg::MIRROR_BYTES - 2), 4'd1, '0);
      send_access(vfm_pkg::OP_MEM_READ, 17'(vfm_pkg::MIRROR_BYTES - 1), 4'd8,
                  64'hfeed_beef_dead_cafe);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::TEXT_REGION_OFFSET), 4'd8,
                  64'h0741_0742_0743_0744);
      send_access(vfm_pkg::OP_MODE_WRITE, 17'd0, 4'd1, {56'd0, vfm_pkg::MODE_TEXT});
      send_access(vfm_pkg::OP_MODE_READ, 17'd0, 4'd1, '0);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'(vfm_pkg::TEXT_REGION_OFFSET), 4'd2, 64'h0f41);
      send_access(vfm_pkg::OP_MEM_WRITE,
                  17'(vfm_pkg::TEXT_REGION_OFFSET + vfm_pkg::TEXT_CELLS - 9), 4'd8, '1);
      send_access(vfm_pkg::OP_MEM_WRITE,
                  17'(vfm_pkg::TEXT_REGION_OFFSET + vfm_pkg::TEXT_CELLS - 8), 4'd8, '1);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'd0, 4'd4, 64'h55);
      send_access(vfm_pkg::OP_MODE_WRITE, 17'd0, 4'd1, 64'hffff_ffff_ffff_ff42);
      send_access(vfm_pkg::OP_MODE_READ, 17'd0, 4'd1, '1);
      send_access(vfm_pkg::OP_MODE_WRITE, 17'h1ffff, 4'd8,
                  {56'hffff_ffff_ffff_ff, vfm_pkg::MODE_VIDEO});
      send_access(vfm_pkg::OP_MEM_READ, 17'(vfm_pkg::TEXT_REGION_OFFSET), 4'd8, '0);

      // Zero-length and oversized counts.
      send_access(vfm_pkg::OP_MEM_WRITE, 17'd40, 4'd0, '1);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'd48, 4'd15, 64'h8877_6655_4433_2211);
      send_access(vfm_pkg::OP_MEM_READ, 17'd40, 4'd12, 64'hdead_beef_0bad_f00d);
      send_access(vfm_pkg::OP_MEM_READ, 17'(vfm_pkg::MIRROR_BYTES - 1), 4'd0, '1);

      // Random phases with the notice enable toggled between them.
      write_clients(1'b1);
      send_access(vfm_pkg::OP_MEM_WRITE, 17'd16, 4'd8, rand_word());
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) idle_enable = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_access();
            // Hold off once per phase until all answers are back.
            if (k == PHASE_ITEMS / 2) drain();
         end
         if (phase < 3) write_clients(phase[0]);
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.due_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
src/vfm_pkg.sv
src/vfm_datapath.sv
src/vfm_controller.sv
src/vga_framebuffer_mirror_unit.sv
bench/vga_framebuffer_mirror_unit_tb.sv
